// ----- src/smbph_pkg.sv -----
// Shared types and constants for the segmented masked base-pattern hit block.
package smbph_pkg;

	localparam int WindowBases = 32;
	localparam int BaseW = 2;
	localparam int WindowW = WindowBases * BaseW;
	localparam int SegLenW = 16;
	localparam int HitCountW = 17;
	localparam int CfgIndexW = 2;
	localparam int CfgDataW = 64;

	// The hit count stops at the segment limit, or at the field's top value if the limit is larger.
	localparam longint MaxSegments = 64'd65536;
	localparam longint HitFieldMax = (64'd1 << HitCountW) - 64'd1;
	localparam longint HitCapL = (MaxSegments > HitFieldMax) ? HitFieldMax : MaxSegments;
	localparam logic [HitCountW-1:0] HitCap = HitCountW'(HitCapL);

	localparam logic [SegLenW-1:0] SegLenReset = 16'd256;

	typedef enum logic [CfgIndexW-1:0] {
		REG_PATTERN_BASES  = 2'd0,
		REG_PATTERN_MASK   = 2'd1,
		REG_SEGMENT_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BaseW-1:0] base;
		logic             start_of_run;
	} in_item_t;

	typedef struct packed {
		logic [SegLenW-1:0]   segment_index;
		logic                 hit;
		logic [HitCountW-1:0] hit_count;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t data;
	} result_push_t;

endpackage

// ----- src/smbph_cell.sv -----
// One window cell: holds one base, passes it to its lower neighbor, compares its incoming base.
module smbph_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [smbph_pkg::BaseW-1:0]   d,
	input  logic [smbph_pkg::BaseW-1:0]   pat,
	input  logic [smbph_pkg::BaseW-1:0]   msk,
	output logic [smbph_pkg::BaseW-1:0]   q,
	output logic                          match
);

	logic [smbph_pkg::BaseW-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (en) begin
			base_q <= d;
		end
	end

	// The compare looks at the base this cell takes on the current transaction.
	assign match = ((d & msk) == pat);
	assign q = base_q;

endmodule

// ----- src/smbph_seg_ctrl.sv -----
// Segment bookkeeping: base count, hit flag, segment index and saturating hit count.
module smbph_seg_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              start_of_run,
	input  logic                              window_match,
	input  logic [smbph_pkg::SegLenW-1:0]     segment_length,
	output smbph_pkg::result_push_t           push
);

	logic [smbph_pkg::SegLenW-1:0]   bases_q;
	logic                            found_q;
	logic [smbph_pkg::SegLenW-1:0]   seg_cnt_q;
	logic [smbph_pkg::HitCountW-1:0] hits_q;

	logic [smbph_pkg::SegLenW-1:0]   bases_cur;
	logic                            found_cur;
	logic [smbph_pkg::SegLenW-1:0]   seg_cnt_cur;
	logic [smbph_pkg::HitCountW-1:0] hits_cur;
	logic [smbph_pkg::SegLenW:0]     n;
	logic                            found_next;
	logic                            seg_end;
	logic [smbph_pkg::HitCountW-1:0] hits_next;

	always_comb begin
		bases_cur   = start_of_run ? '0 : bases_q;
		found_cur   = start_of_run ? 1'b0 : found_q;
		seg_cnt_cur = start_of_run ? '0 : seg_cnt_q;
		hits_cur    = start_of_run ? '0 : hits_q;
		n = {1'b0, bases_cur} + (smbph_pkg::SegLenW+1)'(1);
		// A window counts only once it holds a full window of this segment's bases.
		found_next = found_cur
			| (window_match && (n >= (smbph_pkg::SegLenW+1)'(smbph_pkg::WindowBases)));
		// A count of zero length stands for a full wrap of the counter.
		seg_end = (n[smbph_pkg::SegLenW-1:0] == segment_length);
		hits_next = (found_next && (hits_cur < smbph_pkg::HitCap))
			? hits_cur + smbph_pkg::HitCountW'(1) : hits_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bases_q   <= '0;
			found_q   <= 1'b0;
			seg_cnt_q <= '0;
			hits_q    <= '0;
		end else if (accept) begin
			if (seg_end) begin
				bases_q   <= '0;
				found_q   <= 1'b0;
				seg_cnt_q <= seg_cnt_cur + smbph_pkg::SegLenW'(1);
				hits_q    <= hits_next;
			end else begin
				bases_q   <= n[smbph_pkg::SegLenW-1:0];
				found_q   <= found_next;
				seg_cnt_q <= seg_cnt_cur;
				hits_q    <= hits_cur;
			end
		end
	end

	always_comb begin
		push.valid              = accept && seg_end;
		push.data.segment_index = seg_cnt_cur;
		push.data.hit           = found_next;
		push.data.hit_count     = hits_next;
	end

endmodule

// ----- src/smbph_out_queue.sv -----
// Two-slot output buffer: a presented result and one skid slot behind it.
module smbph_out_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  smbph_pkg::result_push_t   push,
	input  logic                      stall,
	output logic                      valid,
	output smbph_pkg::out_item_t      data,
	output logic                      full
);

	smbph_pkg::out_item_t head_q;
	smbph_pkg::out_item_t spare_q;
	logic [1:0]           count_q;
	logic                 pop;

	assign pop   = (count_q != 2'd0) && !stall;
	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);
	assign data  = head_q;

	always_ff @(posedge clk) begin
		if (push.valid && !pop) begin
			if (count_q == 2'd0) begin
				head_q <= push.data;
			end else begin
				spare_q <= push.data;
			end
		end else if (pop && !push.valid) begin
			head_q <= spare_q;
		end else if (pop && push.valid) begin
			if (count_q == 2'd1) begin
				head_q <= push.data;
			end else begin
				head_q  <= spare_q;
				spare_q <= push.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push.valid && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push.valid) begin
			count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- src/segmented_masked_base_pattern_hit.sv -----
// Top level of the segmented masked base-pattern hit detector.
// One base is taken per clock cycle while in_stall is low; the result for the last base
// of a segment is written into the output buffer and presented from its head slot. The row
// of 32 window cells shifts and compares each accepted base. Results wait in a two-slot
// output buffer, so in_stall rises only while both slots hold results that the receiver has
// not taken. Configuration writes take effect on the next base; pattern bits outside the mask
// never match, so a pattern with such bits set never reports a hit.
module segmented_masked_base_pattern_hit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [smbph_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [smbph_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  smbph_pkg::in_item_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output smbph_pkg::out_item_t                out_data
);

	logic [smbph_pkg::WindowW-1:0] pattern_q;
	logic [smbph_pkg::WindowW-1:0] mask_q;
	logic [smbph_pkg::SegLenW-1:0] seg_len_q;

	logic                               accept;
	logic                               q_full;
	logic [smbph_pkg::WindowW-1:0]      win_q;
	logic [smbph_pkg::WindowBases-1:0]  cell_match;
	logic                               window_match;
	smbph_pkg::result_push_t            res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			mask_q    <= '0;
			seg_len_q <= smbph_pkg::SegLenReset;
		end else if (cfg_we) begin
			case (smbph_pkg::cfg_reg_t'(cfg_index))
				smbph_pkg::REG_PATTERN_BASES:  pattern_q <= cfg_data;
				smbph_pkg::REG_PATTERN_MASK:   mask_q    <= cfg_data;
				smbph_pkg::REG_SEGMENT_LENGTH: seg_len_q <= cfg_data[smbph_pkg::SegLenW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// The newest base enters the top cell; each cell hands its base one place down.
	for (genvar k = 0; k < smbph_pkg::WindowBases; k++) begin : g_cell
		logic [smbph_pkg::BaseW-1:0] cell_d;
		if (k == smbph_pkg::WindowBases - 1) begin : g_top
			assign cell_d = in_data.base;
		end else begin : g_mid
			assign cell_d = win_q[(k+1)*smbph_pkg::BaseW +: smbph_pkg::BaseW];
		end
		smbph_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.d      (cell_d),
			.pat    (pattern_q[k*smbph_pkg::BaseW +: smbph_pkg::BaseW]),
			.msk    (mask_q[k*smbph_pkg::BaseW +: smbph_pkg::BaseW]),
			.q      (win_q[k*smbph_pkg::BaseW +: smbph_pkg::BaseW]),
			.match  (cell_match[k])
		);
	end

	assign window_match = &cell_match;

	smbph_seg_ctrl u_seg_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.start_of_run   (in_data.start_of_run),
		.window_match   (window_match),
		.segment_length (seg_len_q),
		.push           (res_push)
	);

	smbph_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.stall  (out_stall),
		.valid  (out_valid),
		.data   (out_data),
		.full   (q_full)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push.valid |-> !q_full)
		else $error("result produced while the output buffer is full");

	a_hit_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hit_count <= smbph_pkg::HitCap))
		else $error("hit count above its cap");

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |-> (out_data.hit_count != '0))
		else $error("hit segment reported with a zero hit count");

	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> !res_push.valid)
		else $error("result produced without an input transaction");

endmodule
